@@ sv/msort_pkg.sv @@
// ----------------------------------------------------------------------------
// msort_pkg
// Shared constants and types for the merge insertion sorter.
// ----------------------------------------------------------------------------
package msort_pkg;

	localparam int MSORT_MAX_COUNT = 64;
	localparam int MSORT_DATA_W    = 32;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_READ,
		ST_INS_CMP,
		ST_OUT_READ,
		ST_OUT_HOLD
	} msort_state_t;

endpackage

@@ sv/msort_if.sv @@
// ----------------------------------------------------------------------------
// msort_if
// Valid/ready channels for loading values and returning sorted results.
// ----------------------------------------------------------------------------
interface msort_load_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               last_value;

	modport source (output valid, output value, output last_value, input ready);
	modport sink   (input valid, input value, input last_value, output ready);
endinterface

interface msort_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sorted_value;
	logic               last_sorted;
	logic               overflow;

	modport source (output valid, output sorted_value, output last_sorted,
		output overflow, input ready);
	modport sink   (input valid, input sorted_value, input last_sorted,
		input overflow, output ready);
endinterface

@@ sv/merge_insertion_sorter.sv @@
// ----------------------------------------------------------------------------
// merge_insertion_sorter
// Collects signed values into a RAM, keeping it ordered by insertion with one
// shared signed comparator, then bursts the set out in ascending order.
// ----------------------------------------------------------------------------
// Insertion: each larger entry the key passes is read (INS_READ), compared and
//   moved up one slot (INS_CMP) through the single RAM write port and single read port.
// Load is ready only in idle; each burst result is read, then held until taken.
// Reset: asynchronous, clears count, overflow flag and sequencer; the value
//   RAM is not cleared and needs no clearing pass.
module merge_insertion_sorter
	import msort_pkg::*;
#(
	parameter int MAX_COUNT = MSORT_MAX_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	msort_load_if.sink     load,
	msort_result_if.source result
);

	localparam int AW = $clog2(MAX_COUNT);
	localparam int CW = $clog2(MAX_COUNT + 1);

	msort_state_t state_q, state_d;

	logic [CW-1:0]                count_q;
	logic                         dropped_q;
	logic                         last_q;
	logic [AW-1:0]                j_q;
	logic [AW-1:0]                k_q;
	logic signed [MSORT_DATA_W-1:0] key_q;

	logic                    we;
	logic [AW-1:0]           wr_addr;
	logic [MSORT_DATA_W-1:0] wr_data;
	logic [AW-1:0]           rd_addr;
	logic [MSORT_DATA_W-1:0] rd_data;

	logic load_beat;
	logic result_beat;
	logic room;
	logic key_less;
	logic burst_end;

	assign load_beat   = load.valid && load.ready;
	assign result_beat = result.valid && result.ready;
	assign room        = count_q < CW'(MAX_COUNT);
	// shared comparator: key against the entry just read
	assign key_less    = key_q < $signed(rd_data);
	assign burst_end   = (CW'(k_q) + CW'(1)) == count_q;

	msort_ram #(
		.WIDTH (MSORT_DATA_W),
		.DEPTH (MAX_COUNT)
	) u_store (
		.clk     (clk),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (load_beat) begin
					if (room) begin
						state_d = ST_INS_READ;
					end else if (load.last_value) begin
						state_d = ST_OUT_READ;
					end
				end
			end
			ST_INS_READ: begin
				if (j_q == '0) begin
					state_d = last_q ? ST_OUT_READ : ST_IDLE;
				end else begin
					state_d = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				if (key_less) begin
					state_d = ST_INS_READ;
				end else begin
					state_d = last_q ? ST_OUT_READ : ST_IDLE;
				end
			end
			ST_OUT_READ: begin
				state_d = ST_OUT_HOLD;
			end
			ST_OUT_HOLD: begin
				if (result_beat) begin
					state_d = burst_end ? ST_IDLE : ST_OUT_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: RAM port control and handshakes
	always_comb begin
		we           = 1'b0;
		wr_addr      = j_q;
		wr_data      = key_q;
		rd_addr      = j_q - AW'(1);
		load.ready   = 1'b0;
		result.valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				load.ready = 1'b1;
			end
			ST_INS_READ: begin
				// reached the bottom: key goes to slot 0
				we = (j_q == '0);
			end
			ST_INS_CMP: begin
				we = 1'b1;
				if (key_less) begin
					wr_data = rd_data;
				end
			end
			ST_OUT_READ: begin
				rd_addr = k_q;
			end
			ST_OUT_HOLD: begin
				rd_addr      = k_q;
				result.valid = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign result.sorted_value = rd_data;
	assign result.last_sorted  = burst_end;
	assign result.overflow     = dropped_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			last_q    <= 1'b0;
			j_q       <= '0;
			k_q       <= '0;
		end else begin
			state_q <= state_d;
			if (load_beat) begin
				last_q <= load.last_value;
				k_q    <= '0;
				if (room) begin
					j_q     <= AW'(count_q);
					count_q <= count_q + CW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			// entry moved up one slot
			if (state_q == ST_INS_CMP && key_less) begin
				j_q <= j_q - AW'(1);
			end
			if (result_beat) begin
				if (burst_end) begin
					count_q   <= '0;
					dropped_q <= 1'b0;
				end else begin
					k_q <= k_q + AW'(1);
				end
			end
		end
	end

	// key being inserted
	always_ff @(posedge clk) begin
		if (load_beat) begin
			key_q <= load.value;
		end
	end

endmodule

@@ sv/msort_ram.sv @@
// ----------------------------------------------------------------------------
// msort_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ tb/tb_merge_insertion_sorter.sv @@
// ----------------------------------------------------------------------------
// tb_merge_insertion_sorter
// Streams sets of signed values into the sorter and checks each burst against
// a sorted copy kept in the bench. A short directed table comes first, then
// a full and overflowing set, random sets under changing idle and stall rates,
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_merge_insertion_sorter;
	import msort_pkg::*;

	localparam int SET_CAPACITY = MSORT_MAX_COUNT;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int N_DIRECTED   = 21;

	localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic signed [31:0] sorted_value;
		logic               last_sorted;
		logic               overflow;
	} sorted_beat_t;

	// one load beat; typed rows carry their single result beat
	typedef struct {
		logic signed [31:0] value;
		logic               last_value;
		bit                 typed;
		logic signed [31:0] exp_value;
		logic               exp_last;
		logic               exp_overflow;
	} load_row_t;

	logic clk;
	logic arst_n;

	msort_load_if   load_ch ();
	msort_result_if result_ch ();

	merge_insertion_sorter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load_ch),
		.result (result_ch)
	);

	// bench copy of the set being collected, and the bursts still owed
	logic signed [31:0] set_values[$];
	bit                 set_dropped;
	sorted_beat_t       burst[$];
	sorted_beat_t       pending_sorted[$];

	int    mismatches;
	int    idle_pct;
	int    stall_pct;
	bit    hold_req;
	int    cycle_count;
	sorted_beat_t head;

	load_row_t directed_rows [N_DIRECTED] = '{
		// single-value sets: the value comes straight back, marked last
		'{VALUE_MIN, 1'b1, 1'b1, VALUE_MIN, 1'b1, 1'b0},
		'{VALUE_MAX, 1'b1, 1'b1, VALUE_MAX, 1'b1, 1'b0},
		'{32'sd0,    1'b1, 1'b1, 32'sd0,    1'b1, 1'b0},
		'{-32'sd1,   1'b1, 1'b1, -32'sd1,   1'b1, 1'b0},
		// alternating bit patterns mixed with both extremes
		'{32'sh5555_5555, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{32'shAAAA_AAAA, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{VALUE_MAX,      1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{VALUE_MIN,      1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{32'sd0,         1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{-32'sd1,        1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
		// descending input, worst case for insertion
		'{32'sd4, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{32'sd3, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{32'sd2, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{32'sd1, 1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
		// already ascending across zero
		'{-32'sd2, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{-32'sd1, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{32'sd0,  1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
		// duplicates must all survive
		'{32'sd7,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{32'sd7,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{-32'sd7, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{32'sd7,  1'b1, 1'b0, 32'sd0, 1'b0, 1'b0}
	};

	// clock, period 2
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_merge_insertion_sorter failed");
			$finish;
		end
	end

	// add one value to the bench set; a closing value yields the sorted burst
	function automatic void collect_value(input logic signed [31:0] v, input logic closing);
		logic signed [31:0] key;
		int i;
		int j;
		int n;
		burst.delete();
		if (set_values.size() < SET_CAPACITY)
			set_values.insert(set_values.size(), v);
		else
			set_dropped = 1'b1;
		if (!closing)
			return;
		// insertion sort; equal values keep arrival order
		for (i = 1; i < set_values.size(); i++) begin
			key = set_values[i];
			j = i;
			while (j > 0 && key < set_values[j - 1]) begin
				set_values[j] = set_values[j - 1];
				j--;
			end
			set_values[j] = key;
		end
		n = set_values.size();
		for (i = 0; i < n; i++)
			burst.insert(burst.size(),
				sorted_beat_t'{set_values[i], (i == n - 1), set_dropped});
		set_values.delete();
		set_dropped = 1'b0;
	endfunction

	function automatic logic signed [31:0] random_value();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return $urandom;
		if (roll < 80)
			return $urandom_range(8) - 4;
		if (roll < 90) begin
			case ($urandom_range(3))
				0: return VALUE_MIN;
				1: return VALUE_MAX;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		if ($urandom_range(1))
			return VALUE_MIN + $urandom_range(3);
		return VALUE_MAX - $urandom_range(3);
	endfunction

	// offer one load beat, with random idle cycles in front of it
	task automatic send_value(input logic signed [31:0] v, input logic closing, input bit typed);
		if ($urandom_range(99) < idle_pct) begin
			load_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		load_ch.valid      <= 1'b1;
		load_ch.value      <= v;
		load_ch.last_value <= closing;
		do
			@(posedge clk);
		while (!load_ch.ready);
		collect_value(v, closing);
		if (!typed)
			foreach (burst[k])
				pending_sorted.insert(pending_sorted.size(), burst[k]);
	endtask

	task automatic send_set(input int len);
		int i;
		for (i = 0; i < len; i++)
			send_value(random_value(), (i == len - 1), 1'b0);
	endtask

	// sender goes quiet until every owed result has come back
	task automatic drain();
		load_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_sorted.size() != 0);
	endtask

	task automatic run_sets(input int idle, input int stall, input int n_values);
		int sent;
		int len;
		idle_pct  = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < n_values) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			send_set(len);
			sent += len;
		end
		drain();
	endtask

	// receiver: random stalls, or a long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_sorted.size() == 0) begin
				$error("unexpected result beat: sorted_value %0d", result_ch.sorted_value);
				mismatches++;
			end else begin
				head = pending_sorted.pop_front();
				if (result_ch.sorted_value !== head.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d",
						head.sorted_value, result_ch.sorted_value);
					mismatches++;
				end
				if (result_ch.last_sorted !== head.last_sorted) begin
					$error("last_sorted: expected %0b, got %0b",
						head.last_sorted, result_ch.last_sorted);
					mismatches++;
				end
				if (result_ch.overflow !== head.overflow) begin
					$error("overflow: expected %0b, got %0b",
						head.overflow, result_ch.overflow);
					mismatches++;
				end
			end
		end
	end

	// stimulus
	initial begin
		mismatches  = 0;
		idle_pct    = 0;
		stall_pct   = 0;
		hold_req    = 1'b0;
		set_dropped = 1'b0;
		cycle_count <= 0;
		arst_n             <= 1'b0;
		load_ch.valid      <= 1'b0;
		load_ch.value      <= '0;
		load_ch.last_value <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, some receiver stalls
		stall_pct = 30;
		foreach (directed_rows[r]) begin
			send_value(directed_rows[r].value, directed_rows[r].last_value,
				directed_rows[r].typed);
			if (directed_rows[r].typed)
				pending_sorted.insert(pending_sorted.size(),
					sorted_beat_t'{directed_rows[r].exp_value,
					directed_rows[r].exp_last, directed_rows[r].exp_overflow});
		end
		drain();

		// full store, then extra values dropped, the closing one among them
		idle_pct  = 0;
		stall_pct = 0;
		send_set(SET_CAPACITY + $urandom_range(1, 3));
		run_sets(0, 0, 18);
		run_sets(57, 0, 18);
		run_sets(0, 57, 18);

		// long hold-off while the sender keeps offering: input must stall
		hold_req = 1'b1;
		run_sets(8, 8, 18);

		// quiet tail: nothing more may appear
		repeat (2 * SET_CAPACITY + 20) @(posedge clk);
		if (pending_sorted.size() != 0) begin
			$error("%0d expected result beats never arrived", pending_sorted.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("tb_merge_insertion_sorter passed");
		else
			$display("tb_merge_insertion_sorter failed");
		$finish;
	end

endmodule
